// File: hdl/gra_pkg.sv
// ---------------------------------------------------------------------------
// gra_pkg: shared codes for the growing-region bump allocator
// Item kinds on the request stream and status codes on the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

package gra_pkg;

  // Width of the configured region zero size and of a request.
  localparam int unsigned ReqBits = 31;

  // Kind of a request item.
  typedef enum logic [0:0] {
    KIND_ALLOC  = 1'b0,
    KIND_REWIND = 1'b1
  } kind_e;

  // Status of a result item.
  typedef enum logic [2:0] {
    ST_FIT     = 3'd0,
    ST_LATER   = 3'd1,
    ST_NEW     = 3'd2,
    ST_REWOUND = 3'd3,
    ST_FAILED  = 3'd4
  } status_e;

endpackage : gra_pkg

`default_nettype wire

// File: hdl/growing_region_bump_allocator.sv
// ---------------------------------------------------------------------------
// growing_region_bump_allocator: bump allocator over a growing region table
// Hands out offsets in regions; a new region is twice max(last region size, request).
// ---------------------------------------------------------------------------
// A rewind, or an allocate that fits the current region, is answered in the
// cycle after it is accepted, and the next item can be taken in that same
// cycle if the result is being taken. An allocate that does not fit walks
// the later regions through the size memory's single read port, one region
// per cycle. The first later region that is large enough becomes the
// current region and answers the item. When no later region is large
// enough, a final step after the last check appends a region or flags a
// failure. Region zero is not held in the memory; its size is the
// configuration register, so a write to it takes effect at once. Only one
// item is in work at a time.
`default_nettype none

module growing_region_bump_allocator #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned SIZE_BITS   = 32
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // Configuration: size of region zero.
  input  wire  logic        cfg_we_i,
  input  wire  logic [30:0] cfg_wdata_i,
  // Request stream.
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [31:0] s_axis_tdata,   // [30:0] request_bytes, [31] zero
  input  wire  logic [0:0]  s_axis_tuser,   // [0] kind
  // Result stream.
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  // [2:0] status, [6:3] region_index, [38:7] region_offset,
  // [70:39] new_region_bytes, [71] zero
  output logic [71:0]       m_axis_tdata
);

  import gra_pkg::*;

  localparam int unsigned IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW   = $clog2(MAX_REGIONS + 1);
  localparam int unsigned WIDE = ((SIZE_BITS > ReqBits) ? SIZE_BITS : ReqBits) + 1;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SEARCH
  } state_e;

  // Low four bits of a region number.
  function automatic logic [3:0] idx4(input logic [CW-1:0] i);
    logic [CW+3:0] e;
    e = {4'b0, i};
    return e[3:0];
  endfunction

  // Low 32 bits of a size or offset.
  function automatic logic [31:0] w32(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS+31:0] e;
    e = {32'b0, v};
    return e[31:0];
  endfunction

  state_e                 state_q;
  logic [ReqBits-1:0]     cfg_q;
  logic [CW-1:0]          cnt_q;
  logic [IW-1:0]          cur_q;
  logic [SIZE_BITS-1:0]   off_q;
  logic [SIZE_BITS-1:0]   cur_size_q;
  logic [SIZE_BITS-1:0]   last_size_q;
  logic [ReqBits-1:0]     req_q;
  logic [CW-1:0]          j_q;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [3:0]             out_index_q;
  logic [31:0]            out_offset_q;
  logic [31:0]            out_new_q;

  // Region size memory; entry zero is never used.
  logic [SIZE_BITS-1:0]   size_mem [MAX_REGIONS];
  logic [SIZE_BITS-1:0]   rd_data_q;
  logic [IW-1:0]          rd_addr;
  logic                   mem_we;

  // Derived values.
  logic [WIDE-1:0]        cfg_w;
  logic [SIZE_BITS-1:0]   size0;
  logic [WIDE-1:0]        cur_size_w;
  logic [WIDE-1:0]        off_w;
  logic [WIDE-1:0]        in_req_w;
  logic [WIDE-1:0]        req_w;
  logic                   fits;
  logic [CW-1:0]          next_j;
  logic [WIDE-1:0]        last_w;
  logic [WIDE-1:0]        big_w;
  logic                   too_big;
  logic [SIZE_BITS-1:0]   grown;
  logic                   hit;
  logic                   in_fire;
  logic                   out_free;
  logic [SIZE_BITS-1:0]   bumped;
  logic                   out_valid_d;

  // Current region fit check and append arithmetic.
  always_comb begin
    cfg_w      = WIDE'(cfg_q);
    size0      = cfg_w[SIZE_BITS-1:0];
    cur_size_w = (cur_q == '0) ? WIDE'(size0) : WIDE'(cur_size_q);
    off_w      = WIDE'(off_q);
    in_req_w   = WIDE'(s_axis_tdata[ReqBits-1:0]);
    req_w      = WIDE'(req_q);
    fits       = (cur_size_w >= off_w) && ((cur_size_w - off_w) >= in_req_w);
    bumped     = off_q + SIZE_BITS'(s_axis_tdata[ReqBits-1:0]);
    last_w     = (cnt_q == CW'(1)) ? WIDE'(size0) : WIDE'(last_size_q);
    big_w      = (last_w > req_w) ? last_w : req_w;
    too_big    = (big_w[WIDE-1:SIZE_BITS-1] != '0);
    grown      = {big_w[SIZE_BITS-2:0], 1'b0};
    hit        = (WIDE'(rd_data_q) >= req_w);
    next_j     = j_q + CW'(1);
  end

  // Handshake.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // A result is loaded when an item finishes, else the held one clears once taken.
  assign out_valid_d =
    ((state_q == S_IDLE) && in_fire &&
     ((s_axis_tuser[0] == KIND_REWIND) || fits)) ||
    ((state_q == S_SEARCH) && ((j_q >= cnt_q) || hit)) ||
    (out_valid_q && !m_axis_tready);

  // Read address: the next later region during a search, else the one after current.
  always_comb begin
    if (state_q == S_SEARCH) begin
      rd_addr = next_j[IW-1:0];
    end else begin
      rd_addr = IW'(CW'(cur_q) + CW'(1));
    end
  end

  assign mem_we = (state_q == S_SEARCH) && (j_q >= cnt_q) &&
                  (cnt_q < CW'(MAX_REGIONS)) && !too_big;

  // Size memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      size_mem[j_q[IW-1:0]] <= grown;
    end
    rd_data_q <= size_mem[rd_addr];
  end

  // Control state machine and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_q        <= ReqBits'(4096);
      cnt_q        <= CW'(1);
      cur_q        <= '0;
      off_q        <= '0;
      cur_size_q   <= '0;
      last_size_q  <= '0;
      req_q        <= '0;
      j_q          <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_FIT;
      out_index_q  <= '0;
      out_offset_q <= '0;
      out_new_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q <= s_axis_tdata[ReqBits-1:0];
            j_q   <= CW'(cur_q) + CW'(1);
            if (s_axis_tuser[0] == KIND_REWIND) begin
              cur_q        <= '0;
              off_q        <= '0;
              out_status_q <= ST_REWOUND;
              out_index_q  <= '0;
              out_offset_q <= '0;
              out_new_q    <= '0;
            end else if (fits) begin
              off_q        <= bumped;
              out_status_q <= ST_FIT;
              out_index_q  <= idx4(CW'(cur_q));
              out_offset_q <= w32(off_q);
              out_new_q    <= '0;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (j_q >= cnt_q) begin
            // No later region is large enough: append one or fail.
            state_q      <= S_IDLE;
            out_offset_q <= '0;
            if ((cnt_q >= CW'(MAX_REGIONS)) || too_big) begin
              out_status_q <= ST_FAILED;
              out_index_q  <= '0;
              out_new_q    <= '0;
            end else begin
              cnt_q        <= next_j;
              cur_q        <= j_q[IW-1:0];
              cur_size_q   <= grown;
              last_size_q  <= grown;
              off_q        <= SIZE_BITS'(req_q);
              out_status_q <= ST_NEW;
              out_index_q  <= idx4(j_q);
              out_new_q    <= w32(grown);
            end
          end else if (hit) begin
            state_q      <= S_IDLE;
            cur_q        <= j_q[IW-1:0];
            cur_size_q   <= rd_data_q;
            off_q        <= SIZE_BITS'(req_q);
            out_status_q <= ST_LATER;
            out_index_q  <= idx4(j_q);
            out_offset_q <= '0;
            out_new_q    <= '0;
          end else begin
            j_q <= next_j;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_new_q, out_offset_q, out_index_q, out_status_q};

  // The region count stays between one and the table depth.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(MAX_REGIONS)))
    else $error("region count out of range");

  // The current region is always one that exists.
  a_cur_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(cur_q) < cnt_q)
    else $error("current region beyond region count");

  // A search only looks at regions after the current one.
  a_search_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (j_q > CW'(cur_q)))
    else $error("search index not after current region");

  // A rewind is answered in the next cycle.
  a_rewind_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser[0] == KIND_REWIND)) |=>
      (out_valid_q && (out_status_q == ST_REWOUND)))
    else $error("rewind not answered");

  // A failed item reports no region and no new size.
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_FAILED)) |->
      ((out_index_q == '0) && (out_offset_q == '0) && (out_new_q == '0)))
    else $error("failed item carries data");

endmodule : growing_region_bump_allocator

`default_nettype wire
